// ===== src/bled_pkg.sv =====
// bled_pkg: shared constants, codes and a helper function for the bicolor led mode driver
// no dependencies; used by bicolor_led_mode_driver_top through scoped names

package bled_pkg;

    // default geometry of the pwm and sweep logic
    localparam int PWM_STEPS_DEF  = 16;
    localparam int MAX_LEVEL_DEF  = 16;
    localparam int FADE_START_DEF = 16;

    // register widths and reset values
    localparam int MODE_W   = 3;
    localparam int MIX_W    = 5;
    localparam int PERIOD_W = 16;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 4;

    localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RESET = 16'd1000;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF   = 3'd0,
        MODE_ON    = 3'd1,
        MODE_BLINK = 3'd2,
        MODE_FADE  = 3'd3,
        MODE_SWIPE = 3'd4
    } t_led_mode;

    typedef enum logic [1:0] {
        REG_LED_MODE     = 2'd0,
        REG_MIX_LEVEL    = 2'd1,
        REG_BLINK_PERIOD = 2'd2
    } t_reg_idx;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== src/bicolor_led_mode_driver_top.sv =====
// bicolor_led_mode_driver_top: red/green led driver with off, on, blink, fade and swipe modes
// depends on bled_pkg (constants, mode and register codes, max_int)
//
// the led enables of a request show on the output register the cycle after it is taken;
// throughput: 1 request per cycle when not stalled, set by the single output register stage
// reset (synchronous, active low): mode off, mix level 0, blink period 1000, counters cleared,
// sweep level at FADE_START, both leds dark, no result pending

module bicolor_led_mode_driver_top #(
    parameter int PWM_STEPS  = bled_pkg::PWM_STEPS_DEF,
    parameter int MAX_LEVEL  = bled_pkg::MAX_LEVEL_DEF,
    parameter int FADE_START = bled_pkg::FADE_START_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // apb-style configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bled_pkg::ADDR_W-1:0]     paddr,
    input  logic [bled_pkg::DATA_W-1:0]     pwdata,
    output logic [bled_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    // tick request channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_tick,
    // led enable result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_green_on,
    output logic                            o_red_on
);

    // pwm position width
    localparam int PW = $clog2(PWM_STEPS);
    // sweep level holds up to the larger of its reset value and the top pwm position
    localparam int SW = $clog2(bled_pkg::max_int(FADE_START, PWM_STEPS - 1) + 1);
    // common compare width for every level (mix level is 5 bits, sweep may step past PWM_STEPS)
    localparam int LVL_MAX = bled_pkg::max_int(
        bled_pkg::max_int(FADE_START + 1, PWM_STEPS),
        bled_pkg::max_int(MAX_LEVEL, (1 << bled_pkg::MIX_W) - 1));
    localparam int CW = $clog2(LVL_MAX + 1);

    localparam logic [CW-1:0] STEPS_C = CW'(PWM_STEPS);
    localparam logic [CW-1:0] MAX_C   = CW'(MAX_LEVEL);
    localparam logic [SW-1:0] START_C = SW'(FADE_START);
    localparam logic [PW:0]   PWM_END = (PW + 1)'(PWM_STEPS);

    // configuration registers
    bled_pkg::t_led_mode                  r_led_mode;
    logic [bled_pkg::MIX_W-1:0]           r_mix_level;
    logic [bled_pkg::PERIOD_W-1:0]        r_blink_period;

    // running state
    logic [PW-1:0]                        r_pwm_count,    n_pwm_count;
    logic [bled_pkg::PERIOD_W-1:0]        r_period_count, n_period_count;
    logic [SW-1:0]                        r_sweep_level,  n_sweep_level;
    logic                                 r_sweep_up,     n_sweep_up;

    // output register: the held led enables are the result payload
    logic                                 r_out_valid,    n_out_valid;
    logic                                 r_green,        n_green;
    logic                                 r_red,          n_red;

    logic                                 w_cfg_wr;
    bled_pkg::t_reg_idx                   w_reg_idx;
    logic [bled_pkg::MODE_W-1:0]          w_mode_raw;
    logic                                 w_mode_clear;
    logic                                 w_in_acc;
    logic                                 w_step;

    logic [CW-1:0]                        w_sweep_inc;
    logic                                 w_sweep_adv;
    logic                                 w_sweep_wrap;
    logic [CW-1:0]                        w_sweep_next;
    logic                                 w_up_next;
    logic [CW-1:0]                        w_mirror;
    logic [CW-1:0]                        w_level;
    logic                                 w_lit;
    logic                                 w_below;
    logic [PW:0]                          w_pwm_inc;
    logic [bled_pkg::PERIOD_W-1:0]        w_period_inc;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready     = 1'b1;
    assign w_cfg_wr   = psel & penable & pwrite & pready;
    assign w_reg_idx  = bled_pkg::t_reg_idx'(paddr[3:2]);
    assign w_mode_raw = pwdata[bled_pkg::MODE_W-1:0];
    // a mode write that differs from the held mode (raw code, before mapping) restarts counters
    assign w_mode_clear = w_cfg_wr && (w_reg_idx == bled_pkg::REG_LED_MODE) &&
                          (w_mode_raw != r_led_mode);

    always_comb begin
        unique case (w_reg_idx)
            bled_pkg::REG_LED_MODE:     prdata = bled_pkg::DATA_W'(r_led_mode);
            bled_pkg::REG_MIX_LEVEL:    prdata = bled_pkg::DATA_W'(r_mix_level);
            bled_pkg::REG_BLINK_PERIOD: prdata = bled_pkg::DATA_W'(r_blink_period);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_mode     <= bled_pkg::MODE_OFF;
            r_mix_level    <= '0;
            r_blink_period <= bled_pkg::BLINK_PERIOD_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                bled_pkg::REG_LED_MODE: begin
                    // unknown mode codes fall back to off
                    if (w_mode_raw <= bled_pkg::MODE_SWIPE) begin
                        r_led_mode <= bled_pkg::t_led_mode'(w_mode_raw);
                    end else begin
                        r_led_mode <= bled_pkg::MODE_OFF;
                    end
                end
                bled_pkg::REG_MIX_LEVEL:    r_mix_level    <= pwdata[bled_pkg::MIX_W-1:0];
                bled_pkg::REG_BLINK_PERIOD: r_blink_period <= pwdata[bled_pkg::PERIOD_W-1:0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake: a request is taken whenever the output slot is free or draining
    // ------------------------------------------------------------------
    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign w_in_acc   = i_in_valid & o_in_ready;
    assign w_step     = w_in_acc & i_tick;

    // ------------------------------------------------------------------
    // per-tick datapath
    // ------------------------------------------------------------------
    // fade and swipe step the level at the start of each period
    assign w_sweep_adv  = (r_period_count == '0);
    assign w_sweep_inc  = CW'(r_sweep_level) + CW'(1);
    assign w_sweep_wrap = (w_sweep_inc >= STEPS_C);
    assign w_sweep_next = !w_sweep_adv ? CW'(r_sweep_level) :
                          (w_sweep_wrap ? '0 : w_sweep_inc);
    // swipe direction after this tick's wrap, which picks the level shown
    assign w_up_next    = r_sweep_up ^ (w_sweep_adv & w_sweep_wrap);

    // swipe going down shows the mirrored level, saturated at zero
    assign w_mirror = (w_sweep_next <= MAX_C) ? (MAX_C - w_sweep_next) : '0;

    always_comb begin
        w_level = '0;
        w_lit   = 1'b0;
        unique case (r_led_mode)
            bled_pkg::MODE_ON: begin
                w_level = CW'(r_mix_level);
                w_lit   = 1'b1;
            end
            bled_pkg::MODE_BLINK: begin
                // lit for the first half of the period only
                w_level = CW'(r_mix_level);
                w_lit   = (r_period_count < (r_blink_period >> 1));
            end
            bled_pkg::MODE_FADE: begin
                w_level = w_sweep_next;
                w_lit   = 1'b1;
            end
            bled_pkg::MODE_SWIPE: begin
                w_level = w_up_next ? w_sweep_next : w_mirror;
                w_lit   = 1'b1;
            end
            default: begin
                w_level = '0;
                w_lit   = 1'b0;
            end
        endcase
    end

    // green while the pwm position is below the level, red otherwise
    assign w_below = (CW'(r_pwm_count) < w_level);

    assign w_pwm_inc    = {1'b0, r_pwm_count} + (PW + 1)'(1);
    // period counter wraps at 16 bits and restarts on reaching the period
    assign w_period_inc = r_period_count + bled_pkg::PERIOD_W'(1);

    always_comb begin
        n_pwm_count    = r_pwm_count;
        n_period_count = r_period_count;
        n_sweep_level  = r_sweep_level;
        n_sweep_up     = r_sweep_up;
        n_green        = r_green;
        n_red          = r_red;

        if (w_mode_clear) begin
            n_pwm_count    = '0;
            n_period_count = '0;
            n_sweep_level  = START_C;
        end else if (w_step) begin
            n_green = w_lit & w_below;
            n_red   = w_lit & ~w_below;

            if (r_led_mode == bled_pkg::MODE_FADE || r_led_mode == bled_pkg::MODE_SWIPE) begin
                n_sweep_level = SW'(w_sweep_next);
                if (r_led_mode == bled_pkg::MODE_SWIPE && w_sweep_adv && w_sweep_wrap) begin
                    n_sweep_up = ~r_sweep_up;
                end
            end

            n_pwm_count = (w_pwm_inc >= PWM_END) ? '0 : w_pwm_inc[PW-1:0];
            n_period_count = (w_period_inc >= r_blink_period) ? '0 : w_period_inc;
        end
    end

    // result slot fills on every taken request and empties when taken downstream
    always_comb begin
        if (w_in_acc) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_count    <= '0;
            r_period_count <= '0;
            r_sweep_level  <= START_C;
            r_sweep_up     <= 1'b0;
            r_green        <= 1'b0;
            r_red          <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_pwm_count    <= n_pwm_count;
            r_period_count <= n_period_count;
            r_sweep_level  <= n_sweep_level;
            r_sweep_up     <= n_sweep_up;
            r_green        <= n_green;
            r_red          <= n_red;
            r_out_valid    <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_green_on  = r_green;
    assign o_red_on    = r_red;

endmodule

// ===== test/bicolor_led_mode_driver_top_tb.sv =====
// bicolor_led_mode_driver_top_tb: tick-by-tick check of the led enables for all five modes
// depends on bled_pkg (widths, mode and register codes) and bicolor_led_mode_driver_top

module bicolor_led_mode_driver_top_tb;

    // pwm and sweep geometry, same as the block defaults
    localparam int PWM_N      = bled_pkg::PWM_STEPS_DEF;
    localparam int LEVEL_TOP  = bled_pkg::MAX_LEVEL_DEF;
    localparam int SWEEP_INIT = bled_pkg::FADE_START_DEF;

    // byte addresses of the registers, plus one past the end of the map
    localparam logic [bled_pkg::ADDR_W-1:0] ADDR_MODE   = {bled_pkg::REG_LED_MODE, 2'b00};
    localparam logic [bled_pkg::ADDR_W-1:0] ADDR_MIX    = {bled_pkg::REG_MIX_LEVEL, 2'b00};
    localparam logic [bled_pkg::ADDR_W-1:0] ADDR_PERIOD = {bled_pkg::REG_BLINK_PERIOD, 2'b00};
    localparam logic [bled_pkg::ADDR_W-1:0] ADDR_SPARE  = 4'hC;

    localparam int RANDOM_REQUESTS = 1650;
    localparam int QUIET_TAIL      = 300;  // last random requests run with no idling
    localparam int SETTLE_CYCLES   = 4;    // output register latency plus margin
    localparam int STALL_LIMIT     = 2000; // cycles with no handshake before giving up

    typedef struct packed {
        logic green;
        logic red;
    } t_led_pair;

    // clock, reset and every block input start at known values
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          psel        = 1'b0;
    logic                          penable     = 1'b0;
    logic                          pwrite      = 1'b0;
    logic [bled_pkg::ADDR_W-1:0]   paddr       = '0;
    logic [bled_pkg::DATA_W-1:0]   pwdata      = '0;
    logic [bled_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    logic                          i_tick      = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic                          o_green_on;
    logic                          o_red_on;

    always #5 i_clk = ~i_clk;

    bicolor_led_mode_driver_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_tick     (i_tick),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_green_on (o_green_on),
        .o_red_on   (o_red_on)
    );

    // ------------------------------------------------------------------
    // led predictor: own copy of registers and counters
    // ------------------------------------------------------------------
    bled_pkg::t_led_mode cfg_mode   = bled_pkg::MODE_OFF;
    int                  cfg_mix    = 0;
    logic [15:0]         cfg_period = bled_pkg::BLINK_PERIOD_RESET;

    int          pwm_pos    = 0;
    logic [15:0] period_pos = '0;
    int          sweep_lvl  = SWEEP_INIT;
    logic        sweep_rise = 1'b0;
    t_led_pair   held_leds  = '0;

    t_led_pair   led_expect_q[$];
    int          fail_count  = 0;

    // idling controls, changed per phase by the tests
    bit          tx_idle_en  = 1'b0;
    bit          rx_idle_en  = 1'b0;
    int          rx_stall_left = 0;
    int          quiet_cycles  = 0;

    function automatic void restart_counters();
        pwm_pos    = 0;
        period_pos = '0;
        sweep_lvl  = SWEEP_INIT;
    endfunction

    // green while the pwm position is below the level, red otherwise
    function automatic void light_level(input int level);
        held_leds.green = (pwm_pos < level);
        held_leds.red   = !(pwm_pos < level);
    endfunction

    // level steps once per period, wraps at the pwm length
    function automatic void step_sweep(input bit flips);
        if (period_pos == 16'd0) begin
            sweep_lvl++;
            if (sweep_lvl >= PWM_N) begin
                sweep_lvl = 0;
                if (flips) sweep_rise = ~sweep_rise;
            end
        end
    endfunction

    function automatic void predict_leds(input logic tick);
        if (tick) begin
            case (cfg_mode)
                bled_pkg::MODE_ON: begin
                    light_level(cfg_mix);
                end
                bled_pkg::MODE_BLINK: begin
                    if (period_pos < (cfg_period >> 1)) light_level(cfg_mix);
                    else held_leds = '0;
                end
                bled_pkg::MODE_FADE: begin
                    step_sweep(1'b0);
                    light_level(sweep_lvl);
                end
                bled_pkg::MODE_SWIPE: begin
                    step_sweep(1'b1);
                    // falling direction mirrors the level, floored at zero
                    if (sweep_rise) light_level(sweep_lvl);
                    else light_level(sweep_lvl <= LEVEL_TOP ? LEVEL_TOP - sweep_lvl : 0);
                end
                default: begin
                    held_leds = '0;
                end
            endcase
            pwm_pos = (pwm_pos + 1 >= PWM_N) ? 0 : pwm_pos + 1;
            period_pos = period_pos + 16'd1;
            if (period_pos >= cfg_period) period_pos = '0;
        end
        // a low tick repeats the held enables
        led_expect_q.push_back(held_leds);
    endfunction

    // ------------------------------------------------------------------
    // configuration writes, setup then access phase
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [bled_pkg::ADDR_W-1:0] addr,
                             input logic [bled_pkg::DATA_W-1:0] data);
        logic [bled_pkg::MODE_W-1:0] mode_code;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // register takes the write at this edge
        case (bled_pkg::t_reg_idx'(addr[bled_pkg::ADDR_W-1:2]))
            bled_pkg::REG_LED_MODE: begin
                mode_code = data[bled_pkg::MODE_W-1:0];
                // any change of the raw code clears the counters, direction is kept
                if (cfg_mode != mode_code) restart_counters();
                cfg_mode = (mode_code <= bled_pkg::MODE_SWIPE) ?
                           bled_pkg::t_led_mode'(mode_code) : bled_pkg::MODE_OFF;
            end
            bled_pkg::REG_MIX_LEVEL:    cfg_mix    = int'(data[bled_pkg::MIX_W-1:0]);
            bled_pkg::REG_BLINK_PERIOD: cfg_period = data[bled_pkg::PERIOD_W-1:0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // tick request sender: valid stays high back to back unless a gap is taken
    // ------------------------------------------------------------------
    task automatic send_tick(input logic tick);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_tick     <= tick;
        do @(posedge i_clk); while (!o_in_ready);
        predict_leds(tick);
    endtask

    // sender holds off until every predicted result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (led_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // result checker and receiver stall pattern
    // ------------------------------------------------------------------
    t_led_pair want_leds;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (led_expect_q.size() == 0) begin
                $error("result with no request pending: green_on %0b red_on %0b",
                       o_green_on, o_red_on);
                fail_count++;
            end else begin
                want_leds = led_expect_q.pop_front();
                if (o_green_on !== want_leds.green) begin
                    $error("green_on mismatch: expected %0b, actual %0b",
                           want_leds.green, o_green_on);
                    fail_count++;
                end
                if (o_red_on !== want_leds.red) begin
                    $error("red_on mismatch: expected %0b, actual %0b",
                           want_leds.red, o_red_on);
                    fail_count++;
                end
            end
        end
        // ready drops in random bursts while receiver idling is enabled
        if (rx_stall_left != 0) begin
            rx_stall_left <= rx_stall_left - 1;
            i_out_ready   <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
            rx_stall_left <= $urandom_range(1, 13) - 1;
            i_out_ready   <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // out of reset: mode off, leds dark whatever the tick
    task automatic test_reset_defaults();
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        drain_results();
    endtask

    // on mode at no mix, full mix and mix beyond the pwm length
    task automatic test_on_levels();
        apb_write(ADDR_MODE, 32'(bled_pkg::MODE_ON));
        apb_write(ADDR_MIX, 32'd0);
        send_tick(1'b1);
        send_tick(1'b1);
        drain_results();
        apb_write(ADDR_MIX, LEVEL_TOP);
        send_tick(1'b1);
        send_tick(1'b0);
        drain_results();
        apb_write(ADDR_MIX, 32'h1F);
        send_tick(1'b1);
        send_tick(1'b1);
        drain_results();
    endtask

    // blink with zero period stays dark, tiny period toggles
    task automatic test_blink_edges();
        apb_write(ADDR_MIX, 32'd7);
        apb_write(ADDR_PERIOD, 32'd0);
        apb_write(ADDR_MODE, 32'(bled_pkg::MODE_BLINK));
        send_tick(1'b1);
        send_tick(1'b1);
        drain_results();
        apb_write(ADDR_PERIOD, 32'd2);
        repeat (3) send_tick(1'b1);
        drain_results();
    endtask

    // zero period makes fade and swipe step every tick, so wraps and flips come fast
    task automatic test_sweep_fast();
        apb_write(ADDR_PERIOD, 32'd0);
        apb_write(ADDR_MODE, 32'(bled_pkg::MODE_FADE));
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        drain_results();
        apb_write(ADDR_MODE, 32'(bled_pkg::MODE_SWIPE));
        repeat (6) send_tick(1'b1);
        drain_results();
    endtask

    // codes above swipe mean off, rewriting the same mode keeps counters, spare address ignored
    task automatic test_mode_codes();
        apb_write(ADDR_MODE, 32'd7);
        send_tick(1'b1);
        drain_results();
        apb_write(ADDR_MODE, 32'(bled_pkg::MODE_SWIPE));
        apb_write(ADDR_MODE, 32'(bled_pkg::MODE_SWIPE));
        apb_write(ADDR_SPARE, 32'hFFFF_FFFF);
        apb_write(ADDR_PERIOD, 32'hFFFF);
        send_tick(1'b1);
        send_tick(1'b1);
        drain_results();
    endtask

    // period cut below the running count: the count wraps to zero at the next tick
    task automatic test_period_shortened();
        apb_write(ADDR_PERIOD, 32'hFFFF);
        apb_write(ADDR_MIX, 32'd8);
        apb_write(ADDR_MODE, 32'(bled_pkg::MODE_OFF));
        apb_write(ADDR_MODE, 32'(bled_pkg::MODE_BLINK));
        repeat (40) send_tick(1'b1);
        drain_results();
        apb_write(ADDR_PERIOD, 32'd20);
        repeat (60) send_tick(1'b1);
        drain_results();
    endtask

    // new settings between phases, any register may be left as it was
    task automatic write_random_settings();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) apb_write(ADDR_MODE, ($urandom_range(0, 255) << 5) |
                                           $urandom_range(bled_pkg::MODE_OFF,
                                                          bled_pkg::MODE_SWIPE));
        else if (pick == 7) apb_write(ADDR_MODE, $urandom_range(5, 7));
        else if (pick == 8) apb_write(ADDR_MODE, 32'(cfg_mode));
        if ($urandom_range(0, 1) == 0) begin
            if ($urandom_range(0, 9) < 7) apb_write(ADDR_MIX, $urandom_range(0, LEVEL_TOP));
            else apb_write(ADDR_MIX, ($urandom << 5) | $urandom_range(0, 31));
        end
        if ($urandom_range(0, 1) == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) apb_write(ADDR_PERIOD, $urandom_range(0, 3));
            else if (pick < 8) apb_write(ADDR_PERIOD, $urandom_range(4, 64));
            else if (pick == 8) apb_write(ADDR_PERIOD, 32'hFFFF);
            else apb_write(ADDR_PERIOD, $urandom);
        end
    endtask

    // phases of random ticks, mostly high, with random idling per phase
    task automatic test_random_ticks();
        int sent;
        int phase_len;
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            drain_results();
            write_random_settings();
            if (sent >= RANDOM_REQUESTS - QUIET_TAIL) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end else begin
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
            end
            phase_len = $urandom_range(40, 140);
            repeat (phase_len) begin
                send_tick($urandom_range(0, 4) != 0);
                sent++;
            end
        end
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        drain_results();
    endtask

    initial begin
        // synchronous reset, held low from the start and then released
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part with light idling on both sides
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        test_reset_defaults();
        test_on_levels();
        test_blink_edges();
        test_sweep_fast();
        test_mode_codes();

        // period test runs back to back with no idling
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_period_shortened();

        test_random_ticks();

        drain_results();
        if (fail_count == 0 && led_expect_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/bled_pkg.sv
src/bicolor_led_mode_driver_top.sv
test/bicolor_led_mode_driver_top_tb.sv
